FILE: src/dvd_pkg.sv
// ----------------------------------------------------------------------------
// dvd_pkg
// Shared widths, codes and month tables for the date check and difference.
// ----------------------------------------------------------------------------
package dvd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int STATUS_W = 2;
    localparam int ORDER_W  = 2;
    localparam int DIFF_W   = 23;
    localparam int COUNT_W  = 24;
    localparam int Q4_W     = YEAR_W - 2;   // year / 4
    localparam int Q100_W   = 8;            // year / 100, at most 163
    localparam int MOFF_W   = 9;
    localparam int CFG_INDEX_W = 1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_YEAR_FLOOR   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_YEAR = 1'd1;

    localparam logic [YEAR_W-1:0] YEAR_FLOOR_RST   = 14'd1;
    localparam logic [YEAR_W-1:0] CURRENT_YEAR_RST = 14'd2024;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_YEAR  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_MONTH = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_DAY   = 2'd3;

    // Order codes
    localparam logic [ORDER_W-1:0] ORDER_EARLIER = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_LATER   = 2'd2;

    // x / 25 == (x * RECIP_25) >> RECIP_SHIFT for x < 4096
    localparam logic [12:0] RECIP_25    = 13'd5243;
    localparam int          RECIP_SHIFT = 17;
    localparam int          PROD_W      = Q4_W + 13;

    localparam logic signed [COUNT_W-1:0] DAYS_PER_YEAR = 24'sd365;
    localparam logic [COUNT_W-1:0]        DAY_BIAS      = 24'd306;

    localparam logic signed [COUNT_W:0] DIFF_MAX = 25'sd4194303;
    localparam logic signed [COUNT_W:0] DIFF_MIN = -25'sd4194304;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // Non-leap month length, zero for a month outside 1..12
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // (153 * tm - 457) / 5, Jan/Feb (and month 0) taken as months 13/14 (12)
    function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [MOFF_W-1:0] off;
        case (m)
            4'd0:    off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd13:   off = 9'd306;
            4'd14:   off = 9'd337;
            default: off = 9'd367;
        endcase
        return off;
    endfunction

endpackage

FILE: src/date_validate_and_difference.sv
// ----------------------------------------------------------------------------
// date_validate_and_difference
// Checks two Gregorian dates and gives their order and day difference.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with year, month and day of dates a
//   and b. Output channel: out_valid / out_stall with status_a, status_b,
//   order and day_difference (saturated to 23 bits).
//   Configuration: cfg_we with cfg_index and cfg_data writes the year floor
//   (0) or current_year (1); write only while no beat is in flight.
//   Pipeline: each accepted input beat passes through three compute
//   stages (lookup, reciprocal multiply, sum) and then through the
//   difference/saturate output register to the output beat.
//   Rate: one beat per cycle unless stalled; each stage holds one beat.
//   Stall: each stage holds while the next is full and stalled; empty stages
//   still fill, so in_stall rises only when all four stages hold beats.
//   Reset: all stages empty, year floor = 1, current_year = 2024.
// ----------------------------------------------------------------------------
module date_validate_and_difference (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dvd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [dvd_pkg::YEAR_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [dvd_pkg::YEAR_W-1:0]           year_a,
    input  logic [dvd_pkg::MONTH_W-1:0]          month_a,
    input  logic [dvd_pkg::DAY_W-1:0]            day_a,
    input  logic [dvd_pkg::YEAR_W-1:0]           year_b,
    input  logic [dvd_pkg::MONTH_W-1:0]          month_b,
    input  logic [dvd_pkg::DAY_W-1:0]            day_b,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [dvd_pkg::STATUS_W-1:0]         status_a,
    output logic [dvd_pkg::STATUS_W-1:0]         status_b,
    output logic [dvd_pkg::ORDER_W-1:0]          order,
    output logic signed [dvd_pkg::DIFF_W-1:0]    day_difference
);
    import dvd_pkg::*;

    localparam int DATE_W = YEAR_W + MONTH_W + DAY_W;

    // configuration
    logic [YEAR_W-1:0] year_floor_reg;
    logic [YEAR_W-1:0] current_year_reg;
    logic [YEAR_W:0]   year_top;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_floor_reg   <= YEAR_FLOOR_RST;
            current_year_reg <= CURRENT_YEAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_YEAR_FLOOR:   year_floor_reg   <= cfg_data;
                REG_CURRENT_YEAR: current_year_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign year_top = {1'b0, current_year_reg} + 15'd1;

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic ready1, ready2, ready3, ready4;
    stage_en_t en;

    assign ready4 = !v4_reg || !out_stall;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign en.s1 = ready1;
    assign en.s2 = ready2;
    assign en.s3 = ready3;

    assign v1_next = ready1 ? in_valid : v1_reg;
    assign v2_next = ready2 ? v1_reg   : v2_reg;
    assign v3_next = ready3 ? v2_reg   : v3_reg;
    assign v4_next = ready4 ? v3_reg   : v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign in_stall  = !ready1;
    assign out_valid = v4_reg;

    // lexicographic order of the raw fields
    logic [DATE_W-1:0]  date_a;
    logic [DATE_W-1:0]  date_b;
    logic [ORDER_W-1:0] order_next;
    logic [ORDER_W-1:0] order_s1_reg, order_s2_reg, order_s3_reg;

    assign date_a = {year_a, month_a, day_a};
    assign date_b = {year_b, month_b, day_b};

    always_comb
    begin
        if (date_a < date_b)
            order_next = ORDER_EARLIER;
        else if (date_a == date_b)
            order_next = ORDER_EQUAL;
        else
            order_next = ORDER_LATER;
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
            order_s1_reg <= order_next;
        if (en.s2)
            order_s2_reg <= order_s1_reg;
        if (en.s3)
            order_s3_reg <= order_s2_reg;
    end

    // per-date paths
    logic [STATUS_W-1:0]        stat_a, stat_b;
    logic signed [COUNT_W-1:0]  count_a, count_b;

    dvd_date_path u_path_a (
        .clk        (clk),
        .en         (en),
        .year       (year_a),
        .month      (month_a),
        .day        (day_a),
        .year_floor (year_floor_reg),
        .year_top   (year_top),
        .status     (stat_a),
        .count      (count_a)
    );

    dvd_date_path u_path_b (
        .clk        (clk),
        .en         (en),
        .year       (year_b),
        .month      (month_b),
        .day        (day_b),
        .year_floor (year_floor_reg),
        .year_top   (year_top),
        .status     (stat_b),
        .count      (count_b)
    );

    // difference and saturation
    logic signed [COUNT_W:0]    diff;
    logic signed [COUNT_W:0]    diff_sat;

    logic [STATUS_W-1:0]        status_a_reg, status_b_reg;
    logic [ORDER_W-1:0]         order_reg;
    logic signed [DIFF_W-1:0]   diff_reg;

    assign diff = $signed({count_a[COUNT_W-1], count_a}) - $signed({count_b[COUNT_W-1], count_b});

    always_comb
    begin
        if (diff > DIFF_MAX)
            diff_sat = DIFF_MAX;
        else if (diff < DIFF_MIN)
            diff_sat = DIFF_MIN;
        else
            diff_sat = diff;
    end

    always_ff @(posedge clk)
    begin
        if (ready4)
        begin
            status_a_reg <= stat_a;
            status_b_reg <= stat_b;
            order_reg    <= order_s3_reg;
            diff_reg     <= diff_sat[DIFF_W-1:0];
        end
    end

    assign status_a       = status_a_reg;
    assign status_b       = status_b_reg;
    assign order          = order_reg;
    assign day_difference = diff_reg;

`ifndef NO_ASSERTIONS
    // equal dates give zero difference
    a_equal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (order == ORDER_EQUAL)) |-> (day_difference == '0))
        else $error("equal dates with nonzero difference");

    // two valid dates in order earlier must give a negative difference
    a_earlier_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (order == ORDER_EARLIER) && (status_a == STATUS_OK)
         && (status_b == STATUS_OK)) |-> day_difference[DIFF_W-1])
        else $error("earlier valid date without negative difference");

    // an empty first stage never stalls the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> !in_stall)
        else $error("input stalled with empty first stage");

    // a held output beat stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && out_stall) |=> v4_reg)
        else $error("stalled output beat dropped");
`endif

endmodule

FILE: src/dvd_date_path.sv
// ----------------------------------------------------------------------------
// dvd_date_path
// Three-stage check and day count of one date.
// ----------------------------------------------------------------------------
module dvd_date_path (
    input  logic                                 clk,
    input  dvd_pkg::stage_en_t                   en,
    input  logic [dvd_pkg::YEAR_W-1:0]           year,
    input  logic [dvd_pkg::MONTH_W-1:0]          month,
    input  logic [dvd_pkg::DAY_W-1:0]            day,
    input  logic [dvd_pkg::YEAR_W-1:0]           year_floor,
    input  logic [dvd_pkg::YEAR_W:0]             year_top,
    output logic [dvd_pkg::STATUS_W-1:0]         status,
    output logic signed [dvd_pkg::COUNT_W-1:0]   count
);
    import dvd_pkg::*;

    // stage 1: shift year, table lookups, year and month range
    logic                     shift;
    logic signed [YEAR_W:0]   ty;
    logic [Q4_W-1:0]          t4;

    logic signed [YEAR_W:0]   ty_reg;
    logic [Q4_W-1:0]          t4_reg;
    logic [Q4_W-1:0]          y4_reg;
    logic [3:0]               ylow_reg;
    logic [DAY_W-1:0]         day_reg;
    logic [MOFF_W-1:0]        moff_reg;
    logic [DAY_W-1:0]         len_reg;
    logic                     feb_reg;
    logic                     ybad_reg;
    logic                     mbad_reg;

    assign shift = (month < 4'd3);
    assign ty    = $signed({1'b0, year}) - $signed({{YEAR_W{1'b0}}, shift});
    // shifted year is never below -1, whose quotients truncate to zero
    assign t4    = ty[YEAR_W] ? '0 : ty[YEAR_W-1:2];

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            ty_reg   <= ty;
            t4_reg   <= t4;
            y4_reg   <= year[YEAR_W-1:2];
            ylow_reg <= year[3:0];
            day_reg  <= day;
            moff_reg <= month_offset(month);
            len_reg  <= month_days(month);
            feb_reg  <= (month == 4'd2);
            ybad_reg <= (year < year_floor) || ({1'b0, year} > year_top);
            mbad_reg <= (month == 4'd0) || (month > 4'd12);
        end
    end

    // stage 2: divide by 25 through reciprocal, years times 365
    logic [PROD_W-1:0]          q_prod;
    logic [PROD_W-1:0]          r_prod;
    logic signed [COUNT_W-1:0]  y365;

    logic signed [COUNT_W-1:0]  y365_reg;
    logic [Q100_W-1:0]          q_reg;
    logic [Q100_W-1:0]          qr_reg;
    logic [Q4_W-1:0]            t4_s2_reg;
    logic [Q4_W-1:0]            y4_s2_reg;
    logic [3:0]                 ylow_s2_reg;
    logic [DAY_W-1:0]           day_s2_reg;
    logic [MOFF_W-1:0]          moff_s2_reg;
    logic [DAY_W-1:0]           len_s2_reg;
    logic                       feb_s2_reg;
    logic                       ybad_s2_reg;
    logic                       mbad_s2_reg;

    assign q_prod = t4_reg * RECIP_25;
    assign r_prod = y4_reg * RECIP_25;
    assign y365   = COUNT_W'(ty_reg) * DAYS_PER_YEAR;

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            y365_reg    <= y365;
            q_reg       <= q_prod[RECIP_SHIFT +: Q100_W];
            qr_reg      <= r_prod[RECIP_SHIFT +: Q100_W];
            t4_s2_reg   <= t4_reg;
            y4_s2_reg   <= y4_reg;
            ylow_s2_reg <= ylow_reg;
            day_s2_reg  <= day_reg;
            moff_s2_reg <= moff_reg;
            len_s2_reg  <= len_reg;
            feb_s2_reg  <= feb_reg;
            ybad_s2_reg <= ybad_reg;
            mbad_s2_reg <= mbad_reg;
        end
    end

    // stage 3: leap test, day check, day count sum
    logic [Q4_W-1:0]         rem25;
    logic                    leap;
    logic [DAY_W-1:0]        len_full;
    logic                    dbad;
    logic [COUNT_W-1:0]      count_next;
    logic [STATUS_W-1:0]     status_next;

    logic signed [COUNT_W-1:0] count_reg;
    logic [STATUS_W-1:0]       status_reg;

    assign rem25 = y4_s2_reg - Q4_W'(qr_reg * 12'd25);
    // divisible by 4; a multiple of 100 must also be a multiple of 16
    assign leap  = (ylow_s2_reg[1:0] == 2'd0) && ((rem25 != '0) || (ylow_s2_reg == 4'd0));
    assign len_full = len_s2_reg + DAY_W'(feb_s2_reg && leap);
    assign dbad  = (day_s2_reg == '0) || (day_s2_reg > len_full);

    assign count_next = COUNT_W'(y365_reg) + COUNT_W'(t4_s2_reg) - COUNT_W'(q_reg)
                      + COUNT_W'(q_reg[Q100_W-1:2]) + COUNT_W'(moff_s2_reg)
                      + COUNT_W'(day_s2_reg) - DAY_BIAS;

    always_comb
    begin
        if (ybad_s2_reg)
            status_next = STATUS_BAD_YEAR;
        else if (mbad_s2_reg)
            status_next = STATUS_BAD_MONTH;
        else if (dbad)
            status_next = STATUS_BAD_DAY;
        else
            status_next = STATUS_OK;
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            count_reg  <= $signed(count_next);
            status_reg <= status_next;
        end
    end

    assign count  = count_reg;
    assign status = status_reg;

endmodule

FILE: tb/tb_date_validate_and_difference.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_date_validate_and_difference
// Drives date pairs through the checker under several year windows, with
// random gaps and output stalls, and compares every output beat with an
// in-bench prediction of status, order and saturated day difference.
// ----------------------------------------------------------------------------
module tb_date_validate_and_difference;

    import dvd_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 3;
    localparam int SETTLE_CYCLES = 12;   // pipeline is four deep
    localparam int HOLD_CYCLES   = 60;
    localparam int HOLD_AT       = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int DIRECTED_RUN  = 200;
    localparam int PHASE_ITEMS   = 225;
    localparam int PHASES        = 6;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        date_t a;
        date_t b;
    } date_pair_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status_a;
        logic [STATUS_W-1:0] status_b;
        logic [ORDER_W-1:0]  order;
        logic [DIFF_W-1:0]   day_difference;
    } date_result_t;

    // window settings per phase: year floor, current year, idle percent
    int phase_floor [PHASES] = '{1,    9999, 1900, 1,  9999, 1};
    int phase_cur   [PHASES] = '{9998, 9998, 2030, 1,  1,    16383};
    int phase_idle  [PHASES] = '{18,   18,   0,    18, 18,   18};

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [YEAR_W-1:0]          cfg_data;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [YEAR_W-1:0]          year_a = '0;
    logic [MONTH_W-1:0]         month_a = '0;
    logic [DAY_W-1:0]           day_a = '0;
    logic [YEAR_W-1:0]          year_b = '0;
    logic [MONTH_W-1:0]         month_b = '0;
    logic [DAY_W-1:0]           day_b = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [STATUS_W-1:0]        status_a;
    logic [STATUS_W-1:0]        status_b;
    logic [ORDER_W-1:0]         order;
    logic signed [DIFF_W-1:0]   day_difference;

    logic [YEAR_W-1:0]          year_floor_now;
    logic [YEAR_W-1:0]          current_year_now;
    int                         idle_pct = 18;

    date_pair_t                 pending_pairs[$];
    date_result_t               expected_results[$];
    int                         pairs_sent = 0;
    int                         pairs_taken = 0;
    int                         results_seen = 0;
    int                         mismatch_count = 0;
    int                         hold_left = 0;
    bit                         hold_done = 1'b0;

    date_validate_and_difference DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .year_a         (year_a),
        .month_a        (month_a),
        .day_a          (day_a),
        .year_b         (year_b),
        .month_b        (month_b),
        .day_b          (day_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status_a       (status_a),
        .status_b       (status_b),
        .order          (order),
        .day_difference (day_difference)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Date arithmetic
    // ------------------------------------------------------------------------
    function automatic bit is_leap(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(int y, int m);
        int len;
        case (m)
            2:                      len = is_leap(y) ? 29 : 28;
            4, 6, 9, 11:            len = 30;
            1, 3, 5, 7, 8, 10, 12:  len = 31;
            default:                len = 0;
        endcase
        return len;
    endfunction

    function automatic logic [STATUS_W-1:0] date_status(date_t dt);
        int lo;
        int hi;
        int y;
        int m;
        int d;
        lo = int'(year_floor_now);
        hi = int'(current_year_now) + 1;   // no wrap at the top of the window
        y = int'(dt.year);
        m = int'(dt.month);
        d = int'(dt.day);
        if (y < lo || y > hi)
            return STATUS_BAD_YEAR;
        if (m < 1 || m > 12)
            return STATUS_BAD_MONTH;
        if (d < 1 || d > days_in_month(y, m))
            return STATUS_BAD_DAY;
        return STATUS_OK;
    endfunction

    // Day number with Jan/Feb (and month 0) moved to the prior year;
    // all signed so the divisions truncate toward zero.
    function automatic longint day_number(date_t dt);
        longint sy;
        longint sm;
        longint sd;
        sy = longint'(dt.year);
        sm = longint'(dt.month);
        sd = longint'(dt.day);
        if (sm < 3)
        begin
            sy = sy - 1;
            sm = sm + 12;
        end
        return 365 * sy + sy / 4 - sy / 100 + sy / 400 + (153 * sm - 457) / 5 + sd - 306;
    endfunction

    function automatic date_result_t predict_pair(date_pair_t p);
        date_result_t r;
        longint gap;
        r.status_a = date_status(p.a);
        r.status_b = date_status(p.b);
        if (p.a.year != p.b.year)
            r.order = (p.a.year < p.b.year) ? ORDER_EARLIER : ORDER_LATER;
        else if (p.a.month != p.b.month)
            r.order = (p.a.month < p.b.month) ? ORDER_EARLIER : ORDER_LATER;
        else if (p.a.day != p.b.day)
            r.order = (p.a.day < p.b.day) ? ORDER_EARLIER : ORDER_LATER;
        else
            r.order = ORDER_EQUAL;
        gap = day_number(p.a) - day_number(p.b);
        if (gap > DIFF_MAX)
            gap = longint'(DIFF_MAX);
        else if (gap < DIFF_MIN)
            gap = longint'(DIFF_MIN);
        r.day_difference = gap[DIFF_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic date_t ymd(int y, int m, int d);
        date_t dt;
        dt.year = y[YEAR_W-1:0];
        dt.month = m[MONTH_W-1:0];
        dt.day = d[DAY_W-1:0];
        return dt;
    endfunction

    task automatic add_pair(int ya, int ma, int da, int yb, int mb, int db);
        date_pair_t p;
        p.a = ymd(ya, ma, da);
        p.b = ymd(yb, mb, db);
        pending_pairs.push_back(p);
    endtask

    // Mostly dates inside the window, some on its edges and around leap days
    function automatic date_t random_date();
        int lo;
        int hi;
        int y;
        int m;
        int d;
        int len;
        int pick;
        lo = (year_floor_now < 1) ? 1 : int'(year_floor_now);
        hi = int'(current_year_now) + 1;
        if (hi > 9999)
            hi = 9999;
        pick = $urandom_range(99);
        if (pick < 60 && lo <= hi)
            y = $urandom_range(hi, lo);
        else if (pick < 75)
        begin
            case ($urandom_range(3))
                0:       y = int'(year_floor_now) - 1;
                1:       y = int'(year_floor_now);
                2:       y = int'(current_year_now) + 1;
                default: y = int'(current_year_now) + 2;
            endcase
            if (y < 1)
                y = 1;
            if (y > 9999)
                y = 9999;
        end
        else if (pick < 85)
        begin
            case ($urandom_range(5))
                0:       y = 1900;
                1:       y = 2000;
                2:       y = 2023;
                3:       y = 2024;
                4:       y = 2100;
                default: y = 400;
            endcase
        end
        else
            y = $urandom_range(9999, 1);
        m = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(15, 0);
        len = days_in_month(y, m);
        pick = $urandom_range(99);
        if (pick < 70 && len > 0)
            d = $urandom_range(len, 1);
        else if (pick < 85)
            d = len + $urandom_range(1);
        else
            d = $urandom_range(31, 0);
        if (d > 31)
            d = 31;
        return ymd(y, m, d);
    endfunction

    task automatic queue_random_pairs(int count);
        date_pair_t p;
        int shape;
        repeat (count)
        begin
            p.a = random_date();
            p.b = random_date();
            shape = $urandom_range(99);
            if (shape < 12)
                p.b = p.a;
            else if (shape < 30)
            begin
                p.b.year = p.a.year;
                if (shape < 20)
                    p.b.month = p.a.month;
            end
            pending_pairs.push_back(p);
        end
    endtask

    task automatic queue_directed_pairs();
        add_pair(2024, 2, 29, 2024, 2, 29);     // leap day, equal
        add_pair(2023, 2, 29, 2023, 2, 28);     // Feb 29 in a common year
        add_pair(1900, 2, 29, 2000, 2, 29);     // century rule, 400 rule
        add_pair(1, 1, 1, 2025, 12, 31);        // window edges
        add_pair(2026, 1, 1, 2025, 12, 31);     // just past the window
        add_pair(0, 1, 15, 1, 3, 1);            // year zero, Jan: shifted year -1
        add_pair(0, 0, 0, 0, 2, 31);            // month 0 shifted like Jan/Feb
        add_pair(2020, 0, 10, 2020, 13, 10);    // months outside 1..12
        add_pair(2020, 15, 31, 2020, 12, 0);
        add_pair(2024, 4, 31, 2024, 4, 30);     // day past month end
        add_pair(2010, 6, 0, 2010, 6, 31);
        add_pair(16383, 15, 31, 0, 0, 0);       // saturates high
        add_pair(0, 0, 0, 16383, 15, 31);       // saturates low
        add_pair(16383, 12, 31, 1, 1, 1);
        add_pair(9999, 12, 31, 1, 1, 1);        // widest span over years 1..9999
        add_pair(1, 1, 1, 9999, 12, 31);
        add_pair(2024, 1, 1, 2023, 12, 31);
        add_pair(2020, 3, 1, 2020, 2, 29);
        add_pair(2020, 5, 3, 2020, 5, 4);
        add_pair(8191, 8, 16, 8192, 7, 15);
        add_pair(2100, 2, 29, 2400, 2, 29);
        add_pair(2024, 12, 31, 2024, 1, 1);
    endtask

    // ------------------------------------------------------------------------
    // Configuration and phase control
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [YEAR_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_YEAR_FLOOR)
            year_floor_now = value;
        else
            current_year_now = value;
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || pairs_taken != pairs_sent
               || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : run_phases
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_YEAR_FLOOR;
        cfg_data = '0;
        year_floor_now = YEAR_FLOOR_RST;
        current_year_now = CURRENT_YEAR_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        queue_directed_pairs();
        queue_random_pairs(DIRECTED_RUN);
        wait_drained();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_reg(REG_YEAR_FLOOR, YEAR_W'(phase_floor[ph]));
            write_reg(REG_CURRENT_YEAR, YEAR_W'(phase_cur[ph]));
            @(posedge clk);
            idle_pct = phase_idle[ph];
            queue_random_pairs(PHASE_ITEMS);
            wait_drained();
        end
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS date_validate_and_difference");
        else
            $display("FAIL date_validate_and_difference");
        $finish;
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("FAIL date_validate_and_difference");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input beats
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_pairs
        date_pair_t next_pair;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && pairs_taken != pairs_sent)
            ;   // beat still waiting, hold it
        else if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_pct)
        begin
            next_pair = pending_pairs.pop_front();
            year_a <= next_pair.a.year;
            month_a <= next_pair.a.month;
            day_a <= next_pair.a.day;
            year_b <= next_pair.b.year;
            month_b <= next_pair.b.month;
            day_b <= next_pair.b.day;
            in_valid <= 1'b1;
            pairs_sent++;
        end
        else
            in_valid <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Output stall, with one long hold-off to back the pipeline up
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_stall
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < idle_pct);
    end

    // ------------------------------------------------------------------------
    // Prediction on accepted input, check on accepted output
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        date_pair_t   taken;
        date_result_t seen;
        date_result_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            taken.a = {year_a, month_a, day_a};
            taken.b = {year_b, month_b, day_b};
            expected_results.push_back(predict_pair(taken));
            pairs_taken++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            seen = {status_a, status_b, order, day_difference};
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected beat status %0d/%0d order %0d diff %0d",
                             $realtime, status_a, status_b, order, day_difference);
            end
            else
            begin
                want = expected_results.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: beat %0d expected status %0d/%0d order %0d diff %0d,",
                                  " got %0d/%0d order %0d diff %0d"},
                                 $realtime, results_seen, want.status_a, want.status_b,
                                 want.order, $signed(want.day_difference),
                                 status_a, status_b, order, day_difference);
                end
            end
        end
    end

endmodule
